@@ hdl/jdm_pkg.sv @@
// Package for the joystick drive mixer: fixed-point widths, register codes,
// reset values and the side-band record that travels down the pipeline.
// No dependencies.
`default_nettype none

package jdm_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = 1 << (FRAC_BITS - 1);

	localparam int AXIS_W = 16;
	localparam int CFG_W  = 15;
	localparam int VAL_W  = AXIS_W + 1;
	localparam int MAG_W  = AXIS_W;
	localparam int SQP_W  = 2 * VAL_W;
	localparam int SQ_W   = 18;
	localparam int CUP_W  = SQ_W + VAL_W;
	localparam int CU_W   = 19;
	localparam int DIF_W  = CU_W + 1;
	localparam int PP_W   = VAL_W + DIF_W;
	localparam int CUB_W  = 22;
	localparam int SCP_W  = CUB_W + MAG_W + 1;
	localparam int SUM_W  = CUB_W + 1;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_THRUST_DB  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE_DB  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUICK_SENS = 2'd2;

	localparam logic [CFG_W-1:0] THRUST_DB_RESET  = 15'd1638;
	localparam logic [CFG_W-1:0] ROTATE_DB_RESET  = 15'd983;
	localparam logic [CFG_W-1:0] QUICK_SENS_RESET = 15'd0;

	typedef enum logic [1:0] {
		MODE_TANK,
		MODE_ARCADE,
		MODE_QUICK
	} mode_t;

	typedef struct packed {
		mode_t                    mode;
		logic                     high;
		logic                     teleop;
		logic [MAG_W-1:0]         tmag;
		logic signed [VAL_W-1:0]  tank_l;
		logic signed [VAL_W-1:0]  tank_r;
	} ctl_t;

endpackage

`default_nettype wire

@@ hdl/joystick_drive_mixer.sv @@
// Joystick drive mixer top level: ten-stage pipeline from one joystick word
// to one drive word. Depends on jdm_pkg.
// Throughput: one word per cycle; every stage holds a valid bit, and the input
// stalls only when all ten stages are full and m_tready is low. The stage
// count is set by the cubic multiplier chain.
// Reset clears all valid bits and loads the deadband and quick-turn registers
// with their defaults; payload registers are not reset.
`default_nettype none

module joystick_drive_mixer (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output      logic                                  s_tready,
	// left_y_raw, left_z, right_y_raw, right_x, right_z (16 each), then
	// want_high_gear, want_quick_turn, want_arcade, want_reverse, teleop_mode.
	input  wire logic [jdm_pkg::IN_TDATA_W-1:0]        s_tdata,
	output      logic                                  m_tvalid,
	input  wire logic                                  m_tready,
	// left_drive, right_drive (16 each), then high_gear, drive_valid.
	output      logic [jdm_pkg::OUT_TDATA_W-1:0]       m_tdata,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [jdm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [jdm_pkg::CFG_W-1:0]             cfg_data
);

	localparam int LANE_ROT = 0;
	localparam int LANE_THR = 1;
	localparam int NSTAGE   = 10;

	logic [jdm_pkg::CFG_W-1:0] thrust_db_q;
	logic [jdm_pkg::CFG_W-1:0] rotate_db_q;
	logic [jdm_pkg::CFG_W-1:0] quick_sens_q;

	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] en;

	logic signed [jdm_pkg::VAL_W-1:0] v_c  [2];
	logic signed [jdm_pkg::VAL_W-1:0] s_c  [2];
	jdm_pkg::ctl_t                    ctl_c;

	logic signed [jdm_pkg::VAL_W-1:0] v_s1 [2];
	logic signed [jdm_pkg::VAL_W-1:0] s_s1 [2];
	jdm_pkg::ctl_t                    ctl_s1;

	logic signed [jdm_pkg::SQP_W-1:0] sqp_s2 [2];
	logic signed [jdm_pkg::VAL_W-1:0] v_s2   [2];
	logic signed [jdm_pkg::VAL_W-1:0] s_s2   [2];
	jdm_pkg::ctl_t                    ctl_s2;

	logic signed [jdm_pkg::SQ_W-1:0]  sq_c   [2];
	logic signed [jdm_pkg::CUP_W-1:0] cup_s3 [2];
	logic signed [jdm_pkg::VAL_W-1:0] v_s3   [2];
	logic signed [jdm_pkg::VAL_W-1:0] s_s3   [2];
	jdm_pkg::ctl_t                    ctl_s3;

	logic signed [jdm_pkg::CU_W-1:0]  cu_c   [2];
	logic signed [jdm_pkg::DIF_W-1:0] dif_s4 [2];
	logic signed [jdm_pkg::VAL_W-1:0] v_s4   [2];
	logic signed [jdm_pkg::VAL_W-1:0] s_s4   [2];
	jdm_pkg::ctl_t                    ctl_s4;

	logic signed [jdm_pkg::PP_W-1:0]  pp_s5 [2];
	logic signed [jdm_pkg::VAL_W-1:0] v_s5  [2];
	jdm_pkg::ctl_t                    ctl_s5;

	logic signed [jdm_pkg::CUB_W-1:0] cr_c   [2];
	logic signed [jdm_pkg::CUB_W-1:0] cub_s6 [2];
	jdm_pkg::ctl_t                    ctl_s6;

	logic signed [jdm_pkg::SCP_W-1:0] scp_s7;
	logic signed [jdm_pkg::CUB_W-1:0] cub_s7 [2];
	jdm_pkg::ctl_t                    ctl_s7;

	logic signed [jdm_pkg::CUB_W-1:0] rs_c;
	logic signed [jdm_pkg::CUB_W-1:0] rs_s8;
	logic signed [jdm_pkg::CUB_W-1:0] cub_s8 [2];
	jdm_pkg::ctl_t                    ctl_s8;

	logic signed [jdm_pkg::SUM_W-1:0] l_c;
	logic signed [jdm_pkg::SUM_W-1:0] r_c;
	logic signed [jdm_pkg::SUM_W-1:0] l_s9;
	logic signed [jdm_pkg::SUM_W-1:0] r_s9;
	jdm_pkg::ctl_t                    ctl_s9;

	logic signed [jdm_pkg::AXIS_W-1:0] left_s10;
	logic signed [jdm_pkg::AXIS_W-1:0] right_s10;
	logic                              high_s10;
	logic                              dvalid_s10;

	function automatic logic signed [jdm_pkg::AXIS_W-1:0] sat_one(
		input logic signed [jdm_pkg::SUM_W-1:0] x
	);
		logic signed [jdm_pkg::AXIS_W-1:0] y;
		if (x > jdm_pkg::SUM_W'(jdm_pkg::ONE)) begin
			y = jdm_pkg::AXIS_W'(jdm_pkg::ONE);
		end else if (x < -jdm_pkg::SUM_W'(jdm_pkg::ONE)) begin
			y = -jdm_pkg::AXIS_W'(jdm_pkg::ONE);
		end else begin
			y = jdm_pkg::AXIS_W'(x);
		end
		return y;
	endfunction

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thrust_db_q  <= jdm_pkg::THRUST_DB_RESET;
			rotate_db_q  <= jdm_pkg::ROTATE_DB_RESET;
			quick_sens_q <= jdm_pkg::QUICK_SENS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jdm_pkg::REG_THRUST_DB:  thrust_db_q  <= cfg_data;
				jdm_pkg::REG_ROTATE_DB:  rotate_db_q  <= cfg_data;
				jdm_pkg::REG_QUICK_SENS: quick_sens_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when the stage after it moves on.
	always_comb begin
		en[NSTAGE] = !vld_q[NSTAGE] || m_tready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: unpack, direction, deadbands and sensitivities.
	always_comb begin
		logic signed [jdm_pkg::AXIS_W-1:0] ly_raw, lz, ry_raw, rx, rz;
		logic signed [jdm_pkg::VAL_W-1:0]  lyx, ryx, rxx, t0;
		logic signed [jdm_pkg::VAL_W:0]    lz_ofs, rz_ofs;
		logic [jdm_pkg::MAG_W-1:0]         tabs, rabs;
		logic                              rev, t_dead, r_dead;
		logic signed [jdm_pkg::VAL_W-1:0]  st, sr, r_db;

		ly_raw = s_tdata[15:0];
		lz     = s_tdata[31:16];
		ry_raw = s_tdata[47:32];
		rx     = s_tdata[63:48];
		rz     = s_tdata[79:64];
		rev    = s_tdata[83];

		lyx = jdm_pkg::VAL_W'(ly_raw);
		ryx = jdm_pkg::VAL_W'(ry_raw);
		rxx = jdm_pkg::VAL_W'(rx);
		t0  = rev ? lyx : -lyx;

		tabs   = jdm_pkg::MAG_W'(t0[jdm_pkg::VAL_W-1] ? -t0 : t0);
		rabs   = jdm_pkg::MAG_W'(rxx[jdm_pkg::VAL_W-1] ? -rxx : rxx);
		t_dead = tabs < jdm_pkg::MAG_W'(thrust_db_q);
		r_dead = rabs < jdm_pkg::MAG_W'(rotate_db_q);
		r_db   = r_dead ? '0 : rxx;

		lz_ofs = (jdm_pkg::VAL_W + 1)'(lz) + (jdm_pkg::VAL_W + 1)'(jdm_pkg::ONE + 1);
		rz_ofs = (jdm_pkg::VAL_W + 1)'(rz) + (jdm_pkg::VAL_W + 1)'(jdm_pkg::ONE + 1);
		st     = jdm_pkg::VAL_W'(lz_ofs >>> 1);
		sr     = jdm_pkg::VAL_W'(rz_ofs >>> 1);

		priority if (s_tdata[81]) begin
			ctl_c.mode = jdm_pkg::MODE_QUICK;
		end else if (s_tdata[82]) begin
			ctl_c.mode = jdm_pkg::MODE_ARCADE;
		end else begin
			ctl_c.mode = jdm_pkg::MODE_TANK;
		end
		ctl_c.high   = s_tdata[80];
		ctl_c.teleop = s_tdata[84];
		ctl_c.tmag   = t_dead ? '0 : tabs;
		ctl_c.tank_l = t0;
		ctl_c.tank_r = rev ? ryx : -ryx;

		if (s_tdata[81]) begin
			v_c[LANE_ROT] = rxx;
			s_c[LANE_ROT] = jdm_pkg::VAL_W'(quick_sens_q);
		end else begin
			v_c[LANE_ROT] = r_db;
			s_c[LANE_ROT] = sr;
		end
		v_c[LANE_THR] = t_dead ? '0 : t0;
		s_c[LANE_THR] = st;
	end

	// Rounding steps between the multiplier stages.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			sq_c[i] = jdm_pkg::SQ_W'((sqp_s2[i] + jdm_pkg::SQP_W'(jdm_pkg::HALF))
				>>> jdm_pkg::FRAC_BITS);
			cu_c[i] = jdm_pkg::CU_W'((cup_s3[i] + jdm_pkg::CUP_W'(jdm_pkg::HALF))
				>>> jdm_pkg::FRAC_BITS);
			cr_c[i] = jdm_pkg::CUB_W'((pp_s5[i] + jdm_pkg::PP_W'(jdm_pkg::HALF))
				>>> jdm_pkg::FRAC_BITS);
		end
		rs_c = jdm_pkg::CUB_W'((scp_s7 + jdm_pkg::SCP_W'(jdm_pkg::HALF))
			>>> jdm_pkg::FRAC_BITS);
	end

	// Mixing per mode; the left side is inverted in arcade and tank modes.
	always_comb begin
		logic signed [jdm_pkg::SUM_W-1:0] rot, thr, rsx;
		rot = jdm_pkg::SUM_W'(cub_s8[LANE_ROT]);
		thr = jdm_pkg::SUM_W'(cub_s8[LANE_THR]);
		rsx = jdm_pkg::SUM_W'(rs_s8);
		unique case (ctl_s8.mode)
			jdm_pkg::MODE_QUICK: begin
				l_c = rot;
				r_c = -rot;
			end
			jdm_pkg::MODE_ARCADE: begin
				l_c = -(thr + rsx);
				r_c = thr - rsx;
			end
			jdm_pkg::MODE_TANK: begin
				l_c = -jdm_pkg::SUM_W'($signed(ctl_s8.tank_l));
				r_c = jdm_pkg::SUM_W'($signed(ctl_s8.tank_r));
			end
			default: begin
				l_c = '0;
				r_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			v_s1   <= v_c;
			s_s1   <= s_c;
			ctl_s1 <= ctl_c;
		end
		if (en[2]) begin
			for (int i = 0; i < 2; i++) begin
				sqp_s2[i] <= v_s1[i] * v_s1[i];
			end
			v_s2   <= v_s1;
			s_s2   <= s_s1;
			ctl_s2 <= ctl_s1;
		end
		if (en[3]) begin
			for (int i = 0; i < 2; i++) begin
				cup_s3[i] <= sq_c[i] * v_s2[i];
			end
			v_s3   <= v_s2;
			s_s3   <= s_s2;
			ctl_s3 <= ctl_s2;
		end
		if (en[4]) begin
			for (int i = 0; i < 2; i++) begin
				dif_s4[i] <= jdm_pkg::DIF_W'(cu_c[i]) - jdm_pkg::DIF_W'(v_s3[i]);
			end
			v_s4   <= v_s3;
			s_s4   <= s_s3;
			ctl_s4 <= ctl_s3;
		end
		if (en[5]) begin
			for (int i = 0; i < 2; i++) begin
				pp_s5[i] <= s_s4[i] * dif_s4[i];
			end
			v_s5   <= v_s4;
			ctl_s5 <= ctl_s4;
		end
		if (en[6]) begin
			for (int i = 0; i < 2; i++) begin
				cub_s6[i] <= jdm_pkg::CUB_W'(v_s5[i]) + cr_c[i];
			end
			ctl_s6 <= ctl_s5;
		end
		if (en[7]) begin
			scp_s7 <= cub_s6[LANE_ROT] * $signed({1'b0, ctl_s6.tmag});
			cub_s7 <= cub_s6;
			ctl_s7 <= ctl_s6;
		end
		if (en[8]) begin
			rs_s8  <= rs_c;
			cub_s8 <= cub_s7;
			ctl_s8 <= ctl_s7;
		end
		if (en[9]) begin
			l_s9   <= l_c;
			r_s9   <= r_c;
			ctl_s9 <= ctl_s8;
		end
		if (en[10]) begin
			left_s10   <= ctl_s9.teleop ? sat_one(l_s9) : '0;
			right_s10  <= ctl_s9.teleop ? sat_one(r_s9) : '0;
			high_s10   <= ctl_s9.teleop && ctl_s9.high;
			dvalid_s10 <= ctl_s9.teleop;
		end
	end

	assign m_tdata = {6'b0, dvalid_s10, high_s10, right_s10, left_s10};

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q) && !m_tready)
		else $error("input stalled while the pipeline has a free stage");

	a_idle_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !dvalid_s10 |-> left_s10 == '0 && right_s10 == '0 && !high_s10)
		else $error("non-teleop word carries a drive command");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> left_s10 <= jdm_pkg::AXIS_W'(jdm_pkg::ONE)
			&& left_s10 >= -jdm_pkg::AXIS_W'(jdm_pkg::ONE))
		else $error("left drive outside full scale");

	a_right_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> right_s10 <= jdm_pkg::AXIS_W'(jdm_pkg::ONE)
			&& right_s10 >= -jdm_pkg::AXIS_W'(jdm_pkg::ONE))
		else $error("right drive outside full scale");

	a_quick_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[9] && ctl_s9.mode == jdm_pkg::MODE_QUICK |-> l_s9 == -r_s9)
		else $error("quick-turn sides not opposite");

endmodule

`default_nettype wire
